FILE: src/jcs_pkg.sv
// Shared types and constants for the joystick calibrate-and-scale block.
package jcs_pkg;

  // Default ADC sample width.
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // Reset values of the deadzone thresholds.
  localparam int unsigned DZ_HIGH_RESET = 2950;
  localparam int unsigned DZ_LOW_RESET  = 820;

  // Full scale of the percent output and the width of a percent value.
  localparam int unsigned PCT_FULL = 100;
  localparam int unsigned PCT_W    = 8;
  localparam int unsigned PCT_MUL_W = $clog2(PCT_FULL + 1);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_LOW  = 1'b1;

  // Status codes of a result.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CAL_ERR = 2'd1;
  localparam logic [1:0] STATUS_BAD_REQ = 2'd2;

  // Request codes; the two unused codes fall to the default arm.
  typedef enum logic [2:0] {
    REQ_POSITION = 3'd0,
    REQ_CENTER   = 3'd1,
    REQ_Y_MAX    = 3'd2,
    REQ_X_MAX    = 3'd3,
    REQ_Y_MIN    = 3'd4,
    REQ_X_MIN    = 3'd5
  } req_e;

  // One finished result on its way to the output register.
  typedef struct packed {
    logic signed [PCT_W-1:0] pos_x;
    logic signed [PCT_W-1:0] pos_y;
    logic [1:0]              status;
  } res_t;

endpackage

FILE: src/jcs_lane.sv
// One axis lane: span selection, percent scaling by an iterative divider, clipping.
module jcs_lane #(
  parameter int unsigned SAMPLE_BITS = jcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [SAMPLE_BITS-1:0]            raw_i,
  input  logic [SAMPLE_BITS-1:0]            ctr_i,
  input  logic [SAMPLE_BITS-1:0]            hi_i,
  input  logic [SAMPLE_BITS-1:0]            lo_i,
  input  logic                              rising_i,
  output logic                              done_o,
  output logic signed [jcs_pkg::PCT_W-1:0]  pct_o
);

  localparam int unsigned NUM_W = SAMPLE_BITS + jcs_pkg::PCT_MUL_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    L_IDLE,
    L_RUN,
    L_FIN
  } lane_state_e;

  lane_state_e              state_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [NUM_W-1:0]         quo_q, quo_d;
  logic [SAMPLE_BITS-1:0]   rem_q, rem_d;
  logic [SAMPLE_BITS-1:0]   den_q;
  logic                     neg_q, den_zero_q, num_zero_q;
  logic                     done_q;
  logic signed [jcs_pkg::PCT_W-1:0] pct_q;

  // Operand set-up at start.
  logic                     raw_ge_ctr;
  logic [SAMPLE_BITS:0]     den_s;
  logic                     den_neg;
  logic [SAMPLE_BITS-1:0]   den_mag;
  logic [SAMPLE_BITS-1:0]   diff_mag;
  logic [NUM_W-1:0]         num_mag;

  always_comb begin
    raw_ge_ctr = (raw_i >= ctr_i);
    if (raw_ge_ctr && rising_i) begin
      den_s = {1'b0, hi_i} - {1'b0, ctr_i};
    end else begin
      den_s = {1'b0, ctr_i} - {1'b0, lo_i};
    end
    den_neg  = den_s[SAMPLE_BITS];
    den_mag  = den_neg ? SAMPLE_BITS'(-den_s) : den_s[SAMPLE_BITS-1:0];
    diff_mag = raw_ge_ctr ? (raw_i - ctr_i) : (ctr_i - raw_i);
    num_mag  = NUM_W'(diff_mag) * NUM_W'(jcs_pkg::PCT_FULL);
  end

  // One restoring-division step.
  logic [SAMPLE_BITS:0] rem_sh;

  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    if (rem_sh >= {1'b0, den_q}) begin
      rem_d = SAMPLE_BITS'(rem_sh - {1'b0, den_q});
      quo_d = {quo_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[SAMPLE_BITS-1:0];
      quo_d = {quo_q[NUM_W-2:0], 1'b0};
    end
  end

  // Clip the quotient magnitude and apply the sign.
  logic [jcs_pkg::PCT_W-1:0] mag;

  always_comb begin
    if (den_zero_q) begin
      mag = num_zero_q ? '0 : jcs_pkg::PCT_W'(jcs_pkg::PCT_FULL);
    end else if (quo_q > NUM_W'(jcs_pkg::PCT_FULL)) begin
      mag = jcs_pkg::PCT_W'(jcs_pkg::PCT_FULL);
    end else begin
      mag = quo_q[jcs_pkg::PCT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            quo_q      <= num_mag;
            rem_q      <= '0;
            den_q      <= den_mag;
            neg_q      <= (!raw_ge_ctr) ^ den_neg;
            den_zero_q <= (den_mag == '0);
            num_zero_q <= (num_mag == '0);
            cnt_q      <= CNT_W'(NUM_W);
            // A zero span still runs the full count, so both lanes always
            // report done in the same cycle.
            state_q    <= L_RUN;
          end
        end
        L_RUN: begin
          quo_q <= quo_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= L_FIN;
          end
        end
        L_FIN: begin
          pct_q   <= neg_q ? -$signed(mag) : $signed(mag);
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign pct_o  = pct_q;

endmodule

FILE: src/jcs_merge.sv
// Output stage that merges the lane results with the request status.
module jcs_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  input  jcs_pkg::res_t                     res_i,
  output logic                              res_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [jcs_pkg::PCT_W-1:0]  pos_x_o,
  output logic signed [jcs_pkg::PCT_W-1:0]  pos_y_o,
  output logic [1:0]                        status_o
);

  logic          out_valid_q;
  jcs_pkg::res_t out_q;

  // The register takes a new result when it is empty or being emptied.
  assign res_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (res_ready_o) begin
        out_valid_q <= res_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_q.pos_x;
  assign pos_y_o     = out_q.pos_y;
  assign status_o    = out_q.status;

endmodule

FILE: src/joystick_calibrate_and_scale.sv
// Top level of the joystick calibrate-and-scale block: calibration state and request control.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid_i / in_ready_o   req_type_i, first_sample_i, second_sample_i
//   out       source     out_valid_o / out_ready_i pos_x_o, pos_y_o, status_o
//   cfg       sink       cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// A position request runs both axis lanes side by side; each lane is a restoring
// divider that retires one quotient bit per cycle over SAMPLE_BITS+7 bits, also
// when a span is zero. Calibration and invalid requests skip the lanes: their
// result is registered at acceptance and then moves to the output register.
// One request is in work at a time; the next is accepted once the previous result
// has moved to the output register, even while that register still waits for
// out_ready_i.
// Reset is asynchronous and active low and needs no clearing pass.
module joystick_calibrate_and_scale #(
  parameter int unsigned SAMPLE_BITS = jcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        req_type_i,
  input  logic [SAMPLE_BITS-1:0]            first_sample_i,
  input  logic [SAMPLE_BITS-1:0]            second_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [jcs_pkg::PCT_W-1:0]  pos_x_o,
  output logic signed [jcs_pkg::PCT_W-1:0]  pos_y_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_we_i,
  input  logic [jcs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]            cfg_data_i
);

  // All calibration state, held as one record.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] center_x;
    logic [SAMPLE_BITS-1:0] center_y;
    logic [SAMPLE_BITS-1:0] x_high_cal;
    logic [SAMPLE_BITS-1:0] y_high_cal;
    logic [SAMPLE_BITS-1:0] x_low_cal;
    logic [SAMPLE_BITS-1:0] y_low_cal;
    logic                   x_rising;
    logic                   y_rising;
    logic                   axes_swapped;
  } cal_t;

  cal_t                   cal_q, cal_d;
  logic [SAMPLE_BITS-1:0] dz_high_q, dz_low_q;

  // Request control: busy covers the whole life of an accepted request until its
  // result has been handed to the output stage.
  logic       busy_q;
  logic       res_valid_q;
  logic       res_pos_q;
  logic [1:0] res_status_q;
  logic [1:0] status_d;

  logic in_accept;
  logic start;
  logic res_ready;
  logic done_x, done_y;
  logic signed [jcs_pkg::PCT_W-1:0] pct_x, pct_y;
  jcs_pkg::res_t res;

  // Mapped axis samples, following the channel swap found by the Y max capture.
  logic [SAMPLE_BITS-1:0] rx, ry;
  logic [SAMPLE_BITS-1:0] y_high_new;
  logic                   dz_rx, dz_ry;

  function automatic logic in_deadzone(input logic [SAMPLE_BITS-1:0] v,
                                       input logic [SAMPLE_BITS-1:0] hi,
                                       input logic [SAMPLE_BITS-1:0] lo);
    return (v >= hi) || (v <= lo);
  endfunction

  assign in_ready_o = !busy_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign start      = in_accept && (req_type_i == jcs_pkg::REQ_POSITION);

  assign rx    = cal_q.axes_swapped ? second_sample_i : first_sample_i;
  assign ry    = cal_q.axes_swapped ? first_sample_i : second_sample_i;
  assign dz_rx = in_deadzone(rx, dz_high_q, dz_low_q);
  assign dz_ry = in_deadzone(ry, dz_high_q, dz_low_q);

  // Calibration updates and the status of the request, decided at acceptance.
  always_comb begin
    cal_d      = cal_q;
    status_d   = jcs_pkg::STATUS_OK;
    y_high_new = cal_q.y_high_cal;
    case (jcs_pkg::req_e'(req_type_i))
      jcs_pkg::REQ_POSITION: begin
        status_d = jcs_pkg::STATUS_OK;
      end
      jcs_pkg::REQ_CENTER: begin
        cal_d.center_x = rx;
        cal_d.center_y = ry;
        if (rx == '0 || ry == '0) begin
          status_d = jcs_pkg::STATUS_CAL_ERR;
        end
      end
      jcs_pkg::REQ_Y_MAX: begin
        // A deflection found on the X channel means the channels are wired the
        // other way round, so their roles are exchanged.
        if (dz_ry) begin
          y_high_new = ry;
        end else if (dz_rx) begin
          y_high_new         = rx;
          cal_d.axes_swapped = !cal_q.axes_swapped;
        end
        cal_d.y_high_cal = y_high_new;
        if (y_high_new >= dz_high_q) begin
          cal_d.y_rising = 1'b1;
        end else if (y_high_new <= dz_low_q) begin
          cal_d.y_rising = 1'b0;
        end else begin
          status_d = jcs_pkg::STATUS_CAL_ERR;
        end
      end
      jcs_pkg::REQ_X_MAX: begin
        cal_d.x_high_cal = rx;
        if (rx >= dz_high_q) begin
          cal_d.x_rising = 1'b1;
        end else if (rx <= dz_low_q) begin
          cal_d.x_rising = 1'b0;
        end else begin
          status_d = jcs_pkg::STATUS_CAL_ERR;
        end
      end
      jcs_pkg::REQ_Y_MIN: begin
        // The opposite deflection must lie strictly on the far side of the center.
        cal_d.y_low_cal = ry;
        if ((ry >= cal_q.center_y && cal_q.y_rising) ||
            (ry <= cal_q.center_y && !cal_q.y_rising)) begin
          status_d = jcs_pkg::STATUS_CAL_ERR;
        end
      end
      jcs_pkg::REQ_X_MIN: begin
        cal_d.x_low_cal = rx;
        if ((rx >= cal_q.center_x && cal_q.x_rising) ||
            (rx <= cal_q.center_x && !cal_q.x_rising)) begin
          status_d = jcs_pkg::STATUS_CAL_ERR;
        end
      end
      default: begin
        status_d = jcs_pkg::STATUS_BAD_REQ;
      end
    endcase
  end

  // Calibration state and deadzone registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q     <= '0;
      dz_high_q <= SAMPLE_BITS'(jcs_pkg::DZ_HIGH_RESET);
      dz_low_q  <= SAMPLE_BITS'(jcs_pkg::DZ_LOW_RESET);
    end else begin
      if (in_accept) begin
        cal_q <= cal_d;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == jcs_pkg::CFG_DZ_HIGH) begin
          dz_high_q <= cfg_data_i;
        end else begin
          dz_low_q <= cfg_data_i;
        end
      end
    end
  end

  // Request sequencing: a calibration result is ready at once, a position result
  // when both lanes report done. The result then waits until the output stage
  // takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      res_pos_q    <= 1'b0;
      res_status_q <= jcs_pkg::STATUS_OK;
    end else begin
      if (in_accept) begin
        busy_q       <= 1'b1;
        res_valid_q  <= !start;
        res_pos_q    <= start;
        res_status_q <= status_d;
      end else if (res_valid_q && res_ready) begin
        busy_q      <= 1'b0;
        res_valid_q <= 1'b0;
      end else if (done_x && done_y) begin
        res_valid_q <= 1'b1;
      end
    end
  end

  jcs_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .raw_i    (rx),
    .ctr_i    (cal_q.center_x),
    .hi_i     (cal_q.x_high_cal),
    .lo_i     (cal_q.x_low_cal),
    .rising_i (cal_q.x_rising),
    .done_o   (done_x),
    .pct_o    (pct_x)
  );

  jcs_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .raw_i    (ry),
    .ctr_i    (cal_q.center_y),
    .hi_i     (cal_q.y_high_cal),
    .lo_i     (cal_q.y_low_cal),
    .rising_i (cal_q.y_rising),
    .done_o   (done_y),
    .pct_o    (pct_y)
  );

  // The lanes hold their results until the next start, which cannot come before
  // this result has been taken.
  always_comb begin
    res.pos_x  = res_pos_q ? pct_x : '0;
    res.pos_y  = res_pos_q ? pct_y : '0;
    res.status = res_status_q;
  end

  jcs_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid_q),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .status_o    (status_o)
  );

endmodule

FILE: tb/sv/tb_joystick_calibrate_and_scale.sv
// Self-checking testbench for the joystick calibrate-and-scale block.
module tb_joystick_calibrate_and_scale;
  timeunit 1ns;
  timeprecision 1ps;

  // Sample width used in this run, and the largest sample value.
  localparam int SB         = jcs_pkg::SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX = (1 << SB) - 1;
  // Signed copy of the percent full scale so the predictor math stays signed.
  localparam int PCT        = jcs_pkg::PCT_FULL;

  // The two request codes the block must reject.
  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  // Number of random requests, cycles to let pass after the last result, and the
  // cycle limit. The slowest correct run is about 2200 requests, each with at most an
  // idle wait, a busy time and a stall, so it stays well under the limit.
  localparam int RANDOM_REQUESTS = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 1000000;

  // Clock, reset and all block inputs start at known values.
  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          in_valid      = 1'b0;
  logic [2:0]    req_type      = jcs_pkg::REQ_POSITION;
  logic [SB-1:0] first_sample  = '0;
  logic [SB-1:0] second_sample = '0;
  logic          out_ready     = 1'b0;
  logic          cfg_we        = 1'b0;
  logic [jcs_pkg::CFG_IDX_W-1:0] cfg_idx = jcs_pkg::CFG_DZ_HIGH;
  logic [SB-1:0] cfg_data      = '0;

  logic                             in_ready;
  logic                             out_valid;
  logic signed [jcs_pkg::PCT_W-1:0] pos_x;
  logic signed [jcs_pkg::PCT_W-1:0] pos_y;
  logic [1:0]                       status;

  joystick_calibrate_and_scale #(
    .SAMPLE_BITS(SB)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .first_sample_i (first_sample),
    .second_sample_i(second_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pos_x_o        (pos_x),
    .pos_y_o        (pos_y),
    .status_o       (status),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calibration predictor. It mirrors the block's registers and is updated at
  // the clock edge at which each request is accepted, so the stimulus code can
  // look at it to build well-formed calibration sequences.
  // ---------------------------------------------------------------------------
  logic [SB-1:0] dz_high = SB'(jcs_pkg::DZ_HIGH_RESET);
  logic [SB-1:0] dz_low  = SB'(jcs_pkg::DZ_LOW_RESET);
  logic [SB-1:0] ctr_x = '0, ctr_y = '0;
  logic [SB-1:0] span_hi_x = '0, span_hi_y = '0;
  logic [SB-1:0] span_lo_x = '0, span_lo_y = '0;
  logic          x_up = 1'b0, y_up = 1'b0;
  logic          swap_xy = 1'b0;

  // Results predicted for accepted requests, oldest first.
  jcs_pkg::res_t expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned req_histogram[8];
  int unsigned cfg_writes = 0;
  int unsigned swaps_seen = 0;
  int unsigned cycle_count = 0;
  // When set, neither side inserts idle cycles.
  bit          no_idle = 1'b0;

  function automatic bit in_deadzone(logic [SB-1:0] v);
    return (v >= dz_high) || (v <= dz_low);
  endfunction

  // Percent of the calibrated span on one axis, truncated toward zero and
  // clipped to full scale. A zero span saturates by the sign of the offset.
  function automatic logic signed [jcs_pkg::PCT_W-1:0] axis_percent(
    logic [SB-1:0] raw, logic [SB-1:0] ctr, logic [SB-1:0] hi, logic [SB-1:0] lo,
    logic up
  );
    int num, den, q;
    num = (int'(raw) - int'(ctr)) * PCT;
    if (raw >= ctr && up) begin
      den = int'(hi) - int'(ctr);
    end else begin
      den = int'(ctr) - int'(lo);
    end
    if (den == 0) begin
      q = (num > 0) ? PCT : ((num < 0) ? -PCT : 0);
    end else begin
      q = num / den;
      if (q > PCT) q = PCT;
      if (q < -PCT) q = -PCT;
    end
    return q[jcs_pkg::PCT_W-1:0];
  endfunction

  // Applies one request to the mirrored state and returns the result it gives.
  function automatic jcs_pkg::res_t apply_request(logic [2:0] req, logic [SB-1:0] a,
                                                  logic [SB-1:0] b);
    jcs_pkg::res_t r;
    logic [SB-1:0] rx, ry;
    rx = swap_xy ? b : a;
    ry = swap_xy ? a : b;
    r.pos_x  = '0;
    r.pos_y  = '0;
    r.status = jcs_pkg::STATUS_OK;
    case (req)
      jcs_pkg::REQ_POSITION: begin
        r.pos_x = axis_percent(rx, ctr_x, span_hi_x, span_lo_x, x_up);
        r.pos_y = axis_percent(ry, ctr_y, span_hi_y, span_lo_y, y_up);
      end
      jcs_pkg::REQ_CENTER: begin
        ctr_x = rx;
        ctr_y = ry;
        if (rx == 0 || ry == 0) r.status = jcs_pkg::STATUS_CAL_ERR;
      end
      jcs_pkg::REQ_Y_MAX: begin
        // The Y deflection may show up on the X channel; then the roles swap.
        if (in_deadzone(ry)) begin
          span_hi_y = ry;
        end else if (in_deadzone(rx)) begin
          swap_xy   = !swap_xy;
          span_hi_y = rx;
          swaps_seen++;
        end
        if (span_hi_y >= dz_high) y_up = 1'b1;
        else if (span_hi_y <= dz_low) y_up = 1'b0;
        else r.status = jcs_pkg::STATUS_CAL_ERR;
      end
      jcs_pkg::REQ_X_MAX: begin
        span_hi_x = rx;
        if (rx >= dz_high) x_up = 1'b1;
        else if (rx <= dz_low) x_up = 1'b0;
        else r.status = jcs_pkg::STATUS_CAL_ERR;
      end
      jcs_pkg::REQ_Y_MIN: begin
        span_lo_y = ry;
        if ((ry >= ctr_y && y_up) || (ry <= ctr_y && !y_up)) r.status = jcs_pkg::STATUS_CAL_ERR;
      end
      jcs_pkg::REQ_X_MIN: begin
        span_lo_x = rx;
        if ((rx >= ctr_x && x_up) || (rx <= ctr_x && !x_up)) r.status = jcs_pkg::STATUS_CAL_ERR;
      end
      default: r.status = jcs_pkg::STATUS_BAD_REQ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("[%0t] mismatch in result %0d: %s, got %0d, expected %0d",
             $realtime, results_checked, what, got, want);
  endtask

  // Every result taken at a rising edge is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_checker
    jcs_pkg::res_t oldest;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", int'(status), -1);
      end else begin
        oldest = expected_results.pop_front();
        if (pos_x !== oldest.pos_x) report_mismatch("pos_x", int'(pos_x), int'(oldest.pos_x));
        if (pos_y !== oldest.pos_y) report_mismatch("pos_y", int'(pos_y), int'(oldest.pos_y));
        if (status !== oldest.status) begin
          report_mismatch("status", int'(status), int'(oldest.status));
        end
      end
      results_checked++;
    end
  end

  // A hung block ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("FAIL joystick_calibrate_and_scale");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Inputs move at the falling edge; handshakes are seen at the rising
  // edge. Each side draws a random wait per request unless no_idle is set.
  // ---------------------------------------------------------------------------
  function automatic int idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 19);
  endfunction

  // The result side: stall for a drawn number of cycles, then take one result.
  // A zero draw leaves ready high, so back-to-back results can flow.
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = idle_draw();
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  // Sends one request and records its predicted result once it is accepted.
  // Valid is left high afterwards; the next request either replaces the payload
  // at once or lowers valid for its gap, so valid gets one assignment per step.
  task automatic send_request(logic [2:0] req, logic [SB-1:0] a, logic [SB-1:0] b);
    int gap;
    gap = idle_draw();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    first_sample  <= a;
    second_sample <= b;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    expected_results.push_back(apply_request(req, a, b));
    requests_sent++;
    req_histogram[req]++;
  endtask

  // Sends a request given in terms of the current X and Y roles.
  task automatic send_mapped(logic [2:0] req, int x, int y);
    if (swap_xy) send_request(req, y[SB-1:0], x[SB-1:0]);
    else send_request(req, x[SB-1:0], y[SB-1:0]);
  endtask

  // Lowers valid and waits until every result is back and the block is quiet.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes one deadzone register; only called while the block is idle.
  task automatic write_register(logic [jcs_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[SB-1:0];
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == jcs_pkg::CFG_DZ_HIGH) dz_high = value[SB-1:0];
    else dz_low = value[SB-1:0];
    cfg_writes++;
  endtask

  task automatic set_deadzones(int high, int low);
    drain_results();
    write_register(jcs_pkg::CFG_DZ_HIGH, high);
    write_register(jcs_pkg::CFG_DZ_LOW, low);
  endtask

  // ---------------------------------------------------------------------------
  // Value pickers for well-formed calibration sequences.
  // ---------------------------------------------------------------------------
  // A sample in the high or low deadzone, as the direction asks.
  function automatic int deflection(bit high);
    if (high) return $urandom_range(int'(dz_high), SAMPLE_MAX);
    return $urandom_range(0, int'(dz_low));
  endfunction

  // A sample outside both deadzones, when such a sample exists.
  function automatic int between_deadzones();
    if (int'(dz_high) > int'(dz_low) + 1) begin
      return $urandom_range(int'(dz_low) + 1, int'(dz_high) - 1);
    end
    return $urandom_range(0, SAMPLE_MAX);
  endfunction

  // A far-end sample on the side of the centre opposite the direction flag;
  // now and then exactly the centre, which must be flagged.
  function automatic int far_end(int ctr, bit up);
    if ($urandom_range(0, 7) == 0) return ctr;
    if (up) return (ctr > 0) ? $urandom_range(0, ctr - 1) : 0;
    return (ctr < SAMPLE_MAX) ? $urandom_range(ctr + 1, SAMPLE_MAX) : SAMPLE_MAX;
  endfunction

  // A position sample: anywhere, at the rails, or close to the centre.
  function automatic int position_sample(int ctr);
    int v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom_range(0, SAMPLE_MAX);
      2: v = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                  : $urandom_range(SAMPLE_MAX - 63, SAMPLE_MAX);
      default: v = ctr + $urandom_range(0, 100) - 50;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  // One full calibration in the normal order, followed by position requests.
  task automatic calibration_session(int positions);
    bit y_dir, x_dir;
    int cx, cy, v;
    cx = $urandom_range(1024, 3072);
    cy = $urandom_range(1024, 3072);
    send_mapped(jcs_pkg::REQ_CENTER, cx, cy);
    y_dir = $urandom_range(0, 1);
    v = deflection(y_dir);
    // Every fourth session or so the Y deflection arrives on the X channel.
    if ($urandom_range(0, 3) == 0) send_mapped(jcs_pkg::REQ_Y_MAX, v, between_deadzones());
    else send_mapped(jcs_pkg::REQ_Y_MAX, $urandom_range(0, SAMPLE_MAX), v);
    x_dir = $urandom_range(0, 1);
    send_mapped(jcs_pkg::REQ_X_MAX, deflection(x_dir), $urandom_range(0, SAMPLE_MAX));
    send_mapped(jcs_pkg::REQ_Y_MIN, $urandom_range(0, SAMPLE_MAX), far_end(int'(ctr_y), y_up));
    send_mapped(jcs_pkg::REQ_X_MIN, far_end(int'(ctr_x), x_up), $urandom_range(0, SAMPLE_MAX));
    repeat (positions) begin
      send_mapped(jcs_pkg::REQ_POSITION, position_sample(int'(ctr_x)),
                  position_sample(int'(ctr_y)));
    end
  endtask

  // Requests of any code with any samples, including the two unused codes.
  task automatic noise_burst(int count);
    repeat (count) begin
      send_request(3'($urandom_range(0, 7)), SB'($urandom_range(0, SAMPLE_MAX)),
                   SB'($urandom_range(0, SAMPLE_MAX)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Straight out of reset every span is zero, so positions saturate or give 0;
  // the unused codes must be rejected and leave the state alone.
  task automatic test_reset_state();
    send_request(jcs_pkg::REQ_POSITION, '0, '0);
    send_request(jcs_pkg::REQ_POSITION, SB'(SAMPLE_MAX), SB'(SAMPLE_MAX));
    send_request(REQ_UNUSED_6, SB'(SAMPLE_MAX), '0);
    send_request(REQ_UNUSED_7, '0, SB'(SAMPLE_MAX));
  endtask

  // Each calibration step, with and without its error condition, then positions
  // at the centre, at both rails and past the span so the clip is hit.
  task automatic test_calibration_checks();
    send_request(jcs_pkg::REQ_CENTER, '0, 2048);         // zero centre is an error
    send_request(jcs_pkg::REQ_CENTER, 2048, 2048);
    send_request(jcs_pkg::REQ_Y_MAX, 2048, 2000);        // neither channel deflected
    send_request(jcs_pkg::REQ_Y_MAX, 2048, SB'(SAMPLE_MAX));
    send_request(jcs_pkg::REQ_X_MAX, 2000, 2048);        // X not deflected
    send_request(jcs_pkg::REQ_X_MAX, '0, 2048);          // X deflected low
    send_request(jcs_pkg::REQ_Y_MIN, 2048, 2048);        // equal to the centre
    send_request(jcs_pkg::REQ_Y_MIN, 2048, 100);
    send_request(jcs_pkg::REQ_X_MIN, 2048, 2048);        // equal to the centre
    send_request(jcs_pkg::REQ_X_MIN, SB'(SAMPLE_MAX), 2048);
    send_request(jcs_pkg::REQ_POSITION, 2048, 2048);
    send_request(jcs_pkg::REQ_POSITION, '0, SB'(SAMPLE_MAX));
    send_request(jcs_pkg::REQ_POSITION, SB'(SAMPLE_MAX), '0);
    send_request(jcs_pkg::REQ_POSITION, 3000, 3000);
  endtask

  // A Y max capture that finds the deflection on the X channel swaps the roles;
  // a second one in the swapped frame swaps them back.
  task automatic test_axis_swap();
    send_request(jcs_pkg::REQ_Y_MAX, SB'(SAMPLE_MAX), 2048);
    send_request(jcs_pkg::REQ_POSITION, 1000, 3000);
    send_request(jcs_pkg::REQ_Y_MAX, 2048, SB'(SAMPLE_MAX));
  endtask

  // A minimum equal to the centre leaves a zero span: saturate by the sign.
  task automatic test_zero_span();
    send_request(jcs_pkg::REQ_CENTER, 2048, 2048);
    send_request(jcs_pkg::REQ_X_MIN, 2048, 2048);
    send_request(jcs_pkg::REQ_POSITION, 100, 2048);
    send_request(jcs_pkg::REQ_POSITION, 4000, 2048);
  endtask

  // Deadzones at their extremes, crossed over and back at reset, each with a short session and noise.
  task automatic test_deadzone_extremes();
    int highs[5] = '{0, SAMPLE_MAX, 0, SAMPLE_MAX, jcs_pkg::DZ_HIGH_RESET};
    int lows[5]  = '{0, SAMPLE_MAX, SAMPLE_MAX, 0, jcs_pkg::DZ_LOW_RESET};
    for (int i = 0; i < 5; i++) begin
      set_deadzones(highs[i], lows[i]);
      calibration_session(6);
      noise_burst(4);
    end
  endtask

  // Mostly well-formed sessions with random content, some noise, new deadzones
  // every few sessions, and stretches where neither side idles.
  task automatic test_random_sessions();
    int target, session;
    target  = requests_sent + RANDOM_REQUESTS;
    session = 0;
    while (requests_sent < target) begin
      if (session % 8 == 7) begin
        case ($urandom_range(0, 3))
          0: set_deadzones($urandom_range(0, 1) * SAMPLE_MAX, $urandom_range(0, 1) * SAMPLE_MAX);
          1, 2: set_deadzones($urandom_range(2500, SAMPLE_MAX), $urandom_range(0, 1500));
          default: set_deadzones($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
        endcase
      end
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) noise_burst($urandom_range(3, 10));
      else calibration_session($urandom_range(4, 16));
      session++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_calibration_checks();
    test_axis_swap();
    test_zero_span();
    test_deadzone_extremes();
    test_random_sessions();

    drain_results();
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("result never arrived", -1, 0);
    end

    $display("covered %0d requests (position %0d, centre %0d, y max %0d, x max %0d, y min %0d,",
             requests_sent, req_histogram[0], req_histogram[1], req_histogram[2],
             req_histogram[3], req_histogram[4]);
    $display("  x min %0d, rejected %0d), %0d axis swaps, %0d deadzone writes, %0d results checked",
             req_histogram[5], req_histogram[6] + req_histogram[7], swaps_seen, cfg_writes,
             results_checked);
    if (mismatch_count == 0) begin
      $display("PASS joystick_calibrate_and_scale");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL joystick_calibrate_and_scale");
    end
    $finish;
  end

endmodule
